[hdl/vad_pkg.sv]
// Package for the vector angle block: widths, data types and the arctangent table.
// Used by every module of the block; depends on nothing else.
package vad_pkg;

	// Input coordinates and the output angle format.
	localparam int COORD_W    = 8;
	localparam int ANGLE_FRAC = 8;
	localparam int OUT_W      = 16;

	// Rotation engine: number of cells, prescale of the vector and fraction bits of z.
	localparam int STEPS       = 20;
	localparam int PRESCALE_SH = 20;
	localparam int Z_FRAC      = 16;
	localparam int ROUND_SH    = Z_FRAC - ANGLE_FRAC;

	// Derived widths. Dot and cross need one bit more than a product; the rotated
	// vector grows by the engine gain, which two extra bits cover.
	localparam int PROD_W = 2 * COORD_W;
	localparam int DOT_W  = PROD_W + 1;
	localparam int XY_W   = DOT_W + PRESCALE_SH + 2;
	localparam int Z_W    = Z_FRAC + 10;
	localparam int STEP_W = $clog2(STEPS);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [DOT_W-1:0]   dot_t;
	typedef logic signed [XY_W-1:0]    xy_t;
	typedef logic signed [Z_W-1:0]     z_t;
	typedef logic [STEP_W-1:0]         step_t;
	typedef logic [OUT_W-1:0]          angle_t;

	// Angle constants in degrees with Z_FRAC fraction bits.
	localparam z_t Z_90       = z_t'(90 * (2 ** Z_FRAC));
	localparam z_t Z_180      = z_t'(180 * (2 ** Z_FRAC));
	localparam z_t ROUND_HALF = z_t'(2 ** (ROUND_SH - 1));

	// Data handed from one cell to the next. When hold_z is set the angle is
	// already known and the cells pass z through untouched.
	typedef struct packed {
		xy_t  x;
		xy_t  y;
		z_t   z;
		logic hold_z;
		logic degenerate;
	} vad_data_t;

	// atan(2^-step) in degrees, scaled by 2^16 and rounded to nearest.
	function automatic z_t atan_step(input step_t step);
		z_t r;
		case (step)
			step_t'(0):  r = z_t'(2949120);
			step_t'(1):  r = z_t'(1740967);
			step_t'(2):  r = z_t'(919879);
			step_t'(3):  r = z_t'(466945);
			step_t'(4):  r = z_t'(234379);
			step_t'(5):  r = z_t'(117304);
			step_t'(6):  r = z_t'(58666);
			step_t'(7):  r = z_t'(29335);
			step_t'(8):  r = z_t'(14668);
			step_t'(9):  r = z_t'(7334);
			step_t'(10): r = z_t'(3667);
			step_t'(11): r = z_t'(1833);
			step_t'(12): r = z_t'(917);
			step_t'(13): r = z_t'(458);
			step_t'(14): r = z_t'(229);
			step_t'(15): r = z_t'(115);
			step_t'(16): r = z_t'(57);
			step_t'(17): r = z_t'(29);
			step_t'(18): r = z_t'(14);
			step_t'(19): r = z_t'(7);
			default:     r = '0;
		endcase
		return r;
	endfunction

endpackage

[hdl/vad_front.sv]
// Front end of the vector angle block: products, dot and cross, special cases
// and the starting vector for the rotation cells. Depends on vad_pkg.
module vad_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vec_valid,
	output logic               vec_ready,
	input  vad_pkg::coord_t    first_x,
	input  vad_pkg::coord_t    first_y,
	input  vad_pkg::coord_t    second_x,
	input  vad_pkg::coord_t    second_y,
	output vad_pkg::vad_data_t dout,
	output logic               dout_valid,
	input  logic               dout_ready
);

	logic               valid_s1;
	logic               valid_s2;
	logic               ready_s1;
	logic               ready_s2;
	vad_pkg::prod_t     pxx_s1;
	vad_pkg::prod_t     pyy_s1;
	vad_pkg::prod_t     pxy_s1;
	vad_pkg::prod_t     pyx_s1;
	logic               deg_s1;
	vad_pkg::vad_data_t data_s2;
	vad_pkg::dot_t      dot;
	vad_pkg::dot_t      cross_val;
	vad_pkg::dot_t      cross_abs;
	vad_pkg::dot_t      x0;
	vad_pkg::dot_t      y0;
	vad_pkg::vad_data_t start;

	// Each stage moves on when the stage after it is empty or moving too.
	assign ready_s2  = !valid_s2 || dout_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign vec_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= vec_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage 1: the four products and the zero-vector check.
	always_ff @(posedge clk) begin
		if (vec_valid && ready_s1) begin
			pxx_s1 <= first_x * second_x;
			pyy_s1 <= first_y * second_y;
			pxy_s1 <= first_x * second_y;
			pyx_s1 <= first_y * second_x;
			deg_s1 <= ((first_x == '0) && (first_y == '0)) ||
				((second_x == '0) && (second_y == '0));
		end
	end

	// Dot and absolute cross product.
	assign dot       = vad_pkg::dot_t'(pxx_s1) + vad_pkg::dot_t'(pyy_s1);
	assign cross_val = vad_pkg::dot_t'(pxy_s1) - vad_pkg::dot_t'(pyx_s1);
	assign cross_abs = cross_val[vad_pkg::DOT_W-1] ? -cross_val : cross_val;

	// Starting vector: an obtuse pair is first turned by a right angle so that
	// the cells only ever have to cover the first quadrant.
	always_comb begin
		start = '0;
		if (dot[vad_pkg::DOT_W-1]) begin
			x0 = cross_abs;
			y0 = -dot;
			start.z = vad_pkg::Z_90;
		end else begin
			x0 = dot;
			y0 = cross_abs;
			start.z = '0;
		end
		start.x = vad_pkg::xy_t'(x0) <<< vad_pkg::PRESCALE_SH;
		start.y = vad_pkg::xy_t'(y0) <<< vad_pkg::PRESCALE_SH;
		start.degenerate = deg_s1;
		// Cases with an exact answer bypass the rotation.
		if (deg_s1) begin
			start.hold_z = 1'b1;
			start.z = '0;
		end else if (cross_val == '0) begin
			start.hold_z = 1'b1;
			start.z = (dot > 0) ? '0 : vad_pkg::Z_180;
		end else if (dot == '0) begin
			start.hold_z = 1'b1;
			start.z = vad_pkg::Z_90;
		end
	end

	// Stage 2 register feeds the first cell.
	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			data_s2 <= start;
		end
	end

	assign dout       = data_s2;
	assign dout_valid = valid_s2;

endmodule

[hdl/vad_cell.sv]
// One rotation cell of the vectoring chain: a single micro-rotation per item.
// Depends on vad_pkg for the data type and the arctangent table.
module vad_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  vad_pkg::step_t     step,
	input  vad_pkg::vad_data_t din,
	input  logic               din_valid,
	output logic               din_ready,
	output vad_pkg::vad_data_t dout,
	output logic               dout_valid,
	input  logic               dout_ready
);

	logic               valid_q;
	vad_pkg::vad_data_t data_q;
	vad_pkg::vad_data_t nxt;
	vad_pkg::xy_t       xs;
	vad_pkg::xy_t       ys;

	assign din_ready = !valid_q || dout_ready;

	// Shifts round towards minus infinity; both updates use the old x and y.
	assign xs = din.x >>> step;
	assign ys = din.y >>> step;

	// Turn the vector towards the x axis and keep track of the angle turned.
	always_comb begin
		nxt = din;
		if (!din.hold_z) begin
			if (!din.y[vad_pkg::XY_W-1]) begin
				nxt.x = din.x + ys;
				nxt.y = din.y - xs;
				nxt.z = din.z + vad_pkg::atan_step(step);
			end else begin
				nxt.x = din.x - ys;
				nxt.y = din.y + xs;
				nxt.z = din.z - vad_pkg::atan_step(step);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (din_ready) begin
			valid_q <= din_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din_valid && din_ready) begin
			data_q <= nxt;
		end
	end

	assign dout       = data_q;
	assign dout_valid = valid_q;

endmodule

[hdl/vad_back.sv]
// Output stage of the vector angle block: clamp, round and the result register.
// Depends on vad_pkg.
module vad_back (
	input  logic               clk,
	input  logic               arst_n,
	input  vad_pkg::vad_data_t din,
	input  logic               din_valid,
	output logic               din_ready,
	output logic               angle_valid,
	input  logic               angle_ready,
	output vad_pkg::angle_t    angle_degrees_q8,
	output logic               degenerate
);

	logic                                      valid_q;
	vad_pkg::angle_t                           angle_q;
	logic                                      degenerate_q;
	vad_pkg::z_t                               zc;
	vad_pkg::z_t                               zr;
	logic [vad_pkg::Z_W+vad_pkg::OUT_W-1:0]    wide;

	assign din_ready = !valid_q || angle_ready;

	// Clamp to the range 0 to 180 degrees, then round half up to the output format.
	always_comb begin
		if (din.z[vad_pkg::Z_W-1]) begin
			zc = '0;
		end else if (din.z > vad_pkg::Z_180) begin
			zc = vad_pkg::Z_180;
		end else begin
			zc = din.z;
		end
		zr   = zc + vad_pkg::ROUND_HALF;
		wide = {{vad_pkg::OUT_W{1'b0}}, zr} >> vad_pkg::ROUND_SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (din_ready) begin
			valid_q <= din_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din_valid && din_ready) begin
			angle_q      <= wide[vad_pkg::OUT_W-1:0];
			degenerate_q <= din.degenerate;
		end
	end

	assign angle_valid      = valid_q;
	assign angle_degrees_q8 = angle_q;
	assign degenerate       = degenerate_q;

endmodule

[hdl/vector_angle_degrees.sv]
// Angle between two signed 2-D vectors, 0 to 180 degrees, by a vectoring rotation chain.
// An accepted item passes two front stages, twenty rotation cells and one output
// register on its way to the result. Throughput: one item per cycle,
// set by the chain holding one micro-rotation per cell; stalled items pack up.
// Reset clears every stage's valid bit; data registers are not reset.
// Depends on vad_pkg, vad_front, vad_cell and vad_back.
module vector_angle_degrees (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vec_valid,
	output logic            vec_ready,
	input  vad_pkg::coord_t first_x,
	input  vad_pkg::coord_t first_y,
	input  vad_pkg::coord_t second_x,
	input  vad_pkg::coord_t second_y,
	output logic            angle_valid,
	input  logic            angle_ready,
	output vad_pkg::angle_t angle_degrees_q8,
	output logic            degenerate
);

	vad_pkg::vad_data_t cell_data  [0:vad_pkg::STEPS];
	logic               cell_valid [0:vad_pkg::STEPS];
	logic               cell_ready [0:vad_pkg::STEPS];

	// Dot and cross products and the starting vector.
	vad_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.vec_valid  (vec_valid),
		.vec_ready  (vec_ready),
		.first_x    (first_x),
		.first_y    (first_y),
		.second_x   (second_x),
		.second_y   (second_y),
		.dout       (cell_data[0]),
		.dout_valid (cell_valid[0]),
		.dout_ready (cell_ready[0])
	);

	// Chain of rotation cells, one per iteration.
	for (genvar g = 0; g < vad_pkg::STEPS; g++) begin : g_cell
		vad_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.step       (vad_pkg::step_t'(g)),
			.din        (cell_data[g]),
			.din_valid  (cell_valid[g]),
			.din_ready  (cell_ready[g]),
			.dout       (cell_data[g+1]),
			.dout_valid (cell_valid[g+1]),
			.dout_ready (cell_ready[g+1])
		);
	end

	// Rounding and the result register.
	vad_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.din              (cell_data[vad_pkg::STEPS]),
		.din_valid        (cell_valid[vad_pkg::STEPS]),
		.din_ready        (cell_ready[vad_pkg::STEPS]),
		.angle_valid      (angle_valid),
		.angle_ready      (angle_ready),
		.angle_degrees_q8 (angle_degrees_q8),
		.degenerate       (degenerate)
	);

`ifndef SYNTH
	// A zero vector always gives a zero angle.
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid && degenerate |-> angle_degrees_q8 == '0)
		else $error("degenerate item with non-zero angle");

	// The front end marks a zero vector as a fixed angle of zero.
	a_front_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[0] && cell_data[0].degenerate |->
		cell_data[0].hold_z && cell_data[0].z == '0)
		else $error("degenerate item not bypassing the rotation");

	// The last cell holds its item while the output stage is full.
	a_chain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[vad_pkg::STEPS] && !cell_ready[vad_pkg::STEPS] |=>
		cell_valid[vad_pkg::STEPS] && $stable(cell_data[vad_pkg::STEPS]))
		else $error("last cell lost or changed a stalled item");
`endif

endmodule
